FILE: hw/rtl/dtcd_pkg.sv
package dtcd_pkg;

  localparam int COUNT_BITS = 16;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);

  typedef logic [COUNT_BITS-1:0] count_t;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_DOUBLE = 2'd1;
  localparam logic [1:0] KIND_ESCAPE = 2'd2;
  localparam logic [1:0] KIND_END    = 2'd3;

  localparam logic [3:0] LANG_KOREAN = 4'd8;
  localparam logic [3:0] LANG_BIG5   = 4'd9;
  localparam logic [3:0] LANG_SJIS   = 4'd10;
  localparam logic [3:0] LANG_GB     = 4'd11;

  localparam logic [7:0] BYTE_CARET = 8'h5E;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;
  localparam logic [7:0] BYTE_NUL   = 8'h00;

  typedef enum logic [1:0] {
    HELD_NONE,
    HELD_LEAD,
    HELD_CARET
  } held_kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] char_code;
    logic        trailing_punct;
    logic        counted;
    logic [15:0] printable_count;
    logic        last;
  } res_t;

  function automatic logic lead_ok(logic [3:0] lang, logic [7:0] b);
    logic ok;
    case (lang)
      LANG_KOREAN: ok = (b >= 8'hB0) && (b <= 8'hC8);
      LANG_BIG5:   ok = ((b >= 8'hA1) && (b <= 8'hC6)) || ((b >= 8'hC9) && (b <= 8'hF9));
      LANG_SJIS:   ok = ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hEF));
      LANG_GB:     ok = (b >= 8'hA1) && (b <= 8'hF7);
      default:     ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic trail_ok(logic [3:0] lang, logic [7:0] b);
    logic ok;
    case (lang)
      LANG_KOREAN: ok = (b > 8'hA0) && (b != 8'hFF);
      LANG_BIG5:   ok = ((b >= 8'h40) && (b <= 8'h7E)) || ((b >= 8'hA1) && (b != 8'hFF));
      LANG_SJIS:   ok = ((b >= 8'h40) && (b <= 8'h7E)) || ((b >= 8'h80) && (b <= 8'hFC));
      LANG_GB:     ok = (b > 8'hA0) && (b != 8'hFF);
      default:     ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic pair_punct(logic [3:0] lang, logic [15:0] c);
    logic p;
    case (lang)
      LANG_BIG5: p = (c >= 16'hA140) && (c < 16'hA154);
      LANG_SJIS: p = (c >= 16'h8140) && (c < 16'h8152);
      LANG_GB:   p = (c > 16'hA1A0) && (c < 16'hA1AE);
      default:   p = 1'b0;
    endcase
    return p;
  endfunction

  function automatic logic single_punct(logic [7:0] c);
    return (c == 8'h21) || (c == 8'h3F) || (c == 8'h2C) ||
           (c == 8'h2E) || (c == 8'h3B) || (c == 8'h3A);
  endfunction

  function automatic count_t sat_inc(count_t c);
    return (c == '1) ? c : count_t'(c + 1'b1);
  endfunction

  // reported count clamps at 16 bits whatever the counter width
  function automatic logic [15:0] count_report(count_t c);
    return ((c >> 16) != '0) ? 16'hFFFF : 16'(c);
  endfunction

endpackage

FILE: hw/rtl/dtcd_decode.sv
module dtcd_decode
  import dtcd_pkg::*;
(
  input  logic [3:0]  language,
  input  logic [7:0]  text_byte,
  input  logic [7:0]  held_byte,
  input  held_kind_t  held_kind,
  input  count_t      count,
  output logic [1:0]  res_n,
  output res_t        res0,
  output res_t        res1,
  output logic [7:0]  held_byte_nxt,
  output held_kind_t  held_kind_nxt,
  output count_t      count_nxt
);

  logic        fresh;
  logic        pre_emit;
  count_t      c_base;
  res_t        pre_res;
  res_t        fr_res;
  logic        fr_emit;
  logic [15:0] pair_code;

  assign pair_code = {held_byte, text_byte};

  // result from the held byte, if any
  always_comb begin
    pre_res  = '0;
    pre_emit = 1'b0;
    fresh    = 1'b1;
    c_base   = count;
    if (held_kind == HELD_LEAD) begin
      pre_emit = 1'b1;
      c_base   = sat_inc(count);
      pre_res.counted = 1'b1;
      if (lead_ok(language, held_byte) && trail_ok(language, text_byte)) begin
        fresh                  = 1'b0;
        pre_res.kind           = KIND_DOUBLE;
        pre_res.char_code      = pair_code;
        pre_res.trailing_punct = pair_punct(language, pair_code);
      end else begin
        pre_res.kind           = KIND_SINGLE;
        pre_res.char_code      = {8'h00, held_byte};
        pre_res.trailing_punct = single_punct(held_byte);
      end
    end else if (held_kind == HELD_CARET) begin
      pre_emit = 1'b1;
      if ((text_byte >= 8'h30) && (text_byte <= 8'h39)) begin
        fresh             = 1'b0;
        pre_res.kind      = KIND_ESCAPE;
        pre_res.char_code = {8'h00, text_byte};
      end else begin
        c_base            = sat_inc(count);
        pre_res.kind      = KIND_SINGLE;
        pre_res.char_code = {8'h00, BYTE_CARET};
        pre_res.counted   = 1'b1;
      end
    end
    pre_res.printable_count = count_report(c_base);
  end

  // the new byte taken as if nothing were held
  always_comb begin
    fr_res        = '0;
    fr_emit       = 1'b0;
    held_byte_nxt = '0;
    held_kind_nxt = HELD_NONE;
    count_nxt     = c_base;
    if (fresh) begin
      if (text_byte == BYTE_NUL) begin
        fr_emit     = 1'b1;
        fr_res.kind = KIND_END;
        count_nxt   = '0;
      end else if (lead_ok(language, text_byte)) begin
        held_byte_nxt = text_byte;
        held_kind_nxt = HELD_LEAD;
      end else if (text_byte == BYTE_CARET) begin
        held_byte_nxt = text_byte;
        held_kind_nxt = HELD_CARET;
      end else if ((text_byte == BYTE_LF) || (text_byte == BYTE_CR)) begin
        fr_emit          = 1'b1;
        fr_res.kind      = KIND_SINGLE;
        fr_res.char_code = {8'h00, text_byte};
      end else begin
        fr_emit               = 1'b1;
        count_nxt             = sat_inc(c_base);
        fr_res.kind           = KIND_SINGLE;
        fr_res.char_code      = {8'h00, text_byte};
        fr_res.trailing_punct = single_punct(text_byte);
        fr_res.counted        = 1'b1;
      end
    end
    // end of string reports the total before clearing
    fr_res.printable_count = (text_byte == BYTE_NUL) ? count_report(c_base)
                                                     : count_report(count_nxt);
  end

  always_comb begin
    res0  = '0;
    res1  = '0;
    res_n = 2'd0;
    if (pre_emit && fr_emit) begin
      res0      = pre_res;
      res1      = fr_res;
      res1.last = 1'b1;
      res_n     = 2'd2;
    end else if (pre_emit) begin
      res0      = pre_res;
      res0.last = 1'b1;
      res_n     = 2'd1;
    end else if (fr_emit) begin
      res0      = fr_res;
      res0.last = 1'b1;
      res_n     = 2'd1;
    end
  end

endmodule

FILE: hw/rtl/dtcd_out_queue.sv
module dtcd_out_queue
  import dtcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           wr_n,
  input  res_t                 wr0,
  input  res_t                 wr1,
  input  logic                 pop,
  output res_t                 head,
  output logic [QCNT_BITS-1:0] fill
);

  res_t                 mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_nxt;
  logic [QCNT_BITS-1:0] fill_r;
  logic [QCNT_BITS-1:0] fill_nxt;
  logic [QPTR_BITS-1:0] wr_ptr_1;

  assign wr_ptr_1   = QPTR_BITS'(wr_ptr_r + 1'b1);
  assign wr_ptr_nxt = QPTR_BITS'(wr_ptr_r + wr_n);
  assign rd_ptr_nxt = pop ? QPTR_BITS'(rd_ptr_r + 1'b1) : rd_ptr_r;
  assign fill_nxt   = QCNT_BITS'(fill_r + wr_n - pop);
  assign head       = mem_r[rd_ptr_r];
  assign fill       = fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      mem_r[wr_ptr_r] <= wr0;
    end
    if (wr_n == 2'd2) begin
      mem_r[wr_ptr_1] <= wr1;
    end
  end

endmodule

FILE: hw/rtl/dbcs_text_char_decoder_top.sv
// Double-byte text decoder: takes one text byte per item and returns its characters with a
// running printable count. One byte can be accepted every cycle while in_stall is low; an
// accepted byte is registered, and its results go into a four-entry result queue once the queue
// has room for two and leave it at one result per cycle while out_stall is low. A byte that
// releases a held lead or caret as a single character and also yields a character of its own
// gives two results, so the sustained rate is one result per cycle, set by the single output
// port. The language register may only be written while no byte is in flight.
module dbcs_text_char_decoder_top
  import dtcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_char_code,
  output logic        out_trailing_punct,
  output logic        out_counted,
  output logic [15:0] out_printable_count,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_language
);

  logic                 s1_valid_r;
  logic [7:0]           s1_byte_r;
  logic [3:0]           language_r;
  logic [7:0]           held_byte_r;
  logic [7:0]           held_byte_nxt;
  held_kind_t           held_kind_r;
  held_kind_t           held_kind_nxt;
  count_t               count_r;
  count_t               count_nxt;
  logic [1:0]           res_n;
  res_t                 res0;
  res_t                 res1;
  logic [1:0]           wr_n;
  res_t                 head;
  logic [QCNT_BITS-1:0] fill;
  logic                 decode_go;
  logic                 in_take;
  logic                 pop;

  // room for two results regardless of what the output takes this cycle
  assign decode_go = s1_valid_r && (fill <= QCNT_BITS'(QDEPTH - 2));
  assign in_stall  = s1_valid_r && !decode_go;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign wr_n      = decode_go ? res_n : 2'd0;
  assign out_valid = (fill != '0);
  assign pop       = out_valid && !out_stall;

  assign out_kind            = head.kind;
  assign out_char_code       = head.char_code;
  assign out_trailing_punct  = head.trailing_punct;
  assign out_counted         = head.counted;
  assign out_printable_count = head.printable_count;
  assign out_last            = head.last;

  dtcd_decode u_decode (
    .language      (language_r),
    .text_byte     (s1_byte_r),
    .held_byte     (held_byte_r),
    .held_kind     (held_kind_r),
    .count         (count_r),
    .res_n         (res_n),
    .res0          (res0),
    .res1          (res1),
    .held_byte_nxt (held_byte_nxt),
    .held_kind_nxt (held_kind_nxt),
    .count_nxt     (count_nxt)
  );

  dtcd_out_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_n  (wr_n),
    .wr0   (res0),
    .wr1   (res1),
    .pop   (pop),
    .head  (head),
    .fill  (fill)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      language_r  <= '0;
      held_byte_r <= '0;
      held_kind_r <= HELD_NONE;
      count_r     <= '0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (decode_go) begin
        s1_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        language_r <= cfg_language;
      end
      if (decode_go) begin
        held_byte_r <= held_byte_nxt;
        held_kind_r <= held_kind_nxt;
        count_r     <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_text_byte;
    end
  end

endmodule

FILE: bench/dbcs_text_char_decoder_top_test.sv
module dbcs_text_char_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dtcd_pkg::*;

  localparam logic [3:0] LANG_SINGLE     = 4'd0;
  localparam logic [3:0] LANG_SPARE_LO   = 4'd12;
  localparam logic [3:0] LANG_SPARE_13   = 4'd13;
  localparam logic [3:0] LANG_SPARE_TOP  = 4'd15;
  localparam int         PHASE_ITEMS     = 135;
  localparam int         HOLD_OFF_CYCLES = 300;

  // decodes the byte stream alongside the block and keeps the characters still owed
  class dbcs_char_scoreboard;
    logic [3:0]  language;
    held_kind_t  held;
    logic [7:0]  held_byte;
    count_t      total;
    res_t        expected_chars[$];
    int unsigned bytes_in, chars_out, pairs, escapes, ends, mismatches;

    function new();
      language  = LANG_SINGLE;
      held      = HELD_NONE;
      held_byte = '0;
      total     = '0;
    endfunction

    function void set_language(logic [3:0] l);
      language = l;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function bit is_lead(logic [7:0] b);
      case (language)
        LANG_KOREAN: return b >= 8'hB0 && b <= 8'hC8;
        LANG_BIG5:   return b >= 8'hA1 && b <= 8'hF9 && b != 8'hC7 && b != 8'hC8;
        LANG_SJIS:   return (b >= 8'h81 && b < 8'hA0) || (b >= 8'hE0 && b < 8'hF0);
        LANG_GB:     return b >= 8'hA1 && b <= 8'hF7;
        default:     return 1'b0;
      endcase
    endfunction

    function bit is_trail(logic [7:0] b);
      case (language)
        LANG_KOREAN, LANG_GB: return b >= 8'hA1 && b <= 8'hFE;
        LANG_BIG5: return (b >= 8'h40 && b <= 8'h7E) || (b >= 8'hA1 && b <= 8'hFE);
        LANG_SJIS: return (b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC);
        default:   return 1'b0;
      endcase
    endfunction

    function bit pair_is_punct(logic [15:0] c);
      case (language)
        LANG_BIG5: return c >= 16'hA140 && c <= 16'hA153;
        LANG_SJIS: return c >= 16'h8140 && c <= 16'h8151;
        LANG_GB:   return c >= 16'hA1A1 && c <= 16'hA1AD;
        default:   return 1'b0;
      endcase
    endfunction

    function bit ascii_punct(logic [7:0] b);
      case (b)
        8'h21, 8'h3F, 8'h2C, 8'h2E, 8'h3B, 8'h3A: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // counted characters bump the length before it is reported
    function void add_char(logic [1:0] kind, logic [15:0] code, bit punct, bit counted);
      res_t r;
      if (counted && total != '1)
        total++;
      r.kind            = kind;
      r.char_code       = code;
      r.trailing_punct  = punct;
      r.counted         = counted;
      r.printable_count = (total > 'hFFFF) ? 16'hFFFF : 16'(total);
      r.last            = 1'b0;
      expected_chars.insert(expected_chars.size(), r);
    endfunction

    function void take_fresh(logic [7:0] b);
      if (b == BYTE_NUL) begin
        add_char(KIND_END, 16'h0000, 1'b0, 1'b0);
        total     = '0;
        held      = HELD_NONE;
        held_byte = '0;
      end else if (is_lead(b)) begin
        held      = HELD_LEAD;
        held_byte = b;
      end else if (b == BYTE_CARET) begin
        held      = HELD_CARET;
        held_byte = b;
      end else if (b == BYTE_LF || b == BYTE_CR) begin
        add_char(KIND_SINGLE, {8'h00, b}, 1'b0, 1'b0);
      end else begin
        add_char(KIND_SINGLE, {8'h00, b}, ascii_punct(b), 1'b1);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      int          before_n;
      logic [15:0] code;
      before_n = expected_chars.size();
      bytes_in++;
      case (held)
        HELD_LEAD: begin
          code      = {held_byte, b};
          held      = HELD_NONE;
          // lead is judged by the language in force when the trail turns up
          if (is_lead(held_byte) && is_trail(b))
            add_char(KIND_DOUBLE, code, pair_is_punct(code), 1'b1);
          else begin
            add_char(KIND_SINGLE, {8'h00, held_byte}, ascii_punct(held_byte), 1'b1);
            take_fresh(b);
          end
        end
        HELD_CARET: begin
          held = HELD_NONE;
          if (b >= 8'h30 && b <= 8'h39)
            add_char(KIND_ESCAPE, {8'h00, b}, 1'b0, 1'b0);
          else begin
            add_char(KIND_SINGLE, {8'h00, BYTE_CARET}, 1'b0, 1'b1);
            take_fresh(b);
          end
        end
        default: take_fresh(b);
      endcase
      if (expected_chars.size() > before_n)
        expected_chars[expected_chars.size() - 1].last = 1'b1;
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_char(res_t got);
      res_t want;
      if (expected_chars.size() == 0) begin
        $error("result with nothing outstanding: kind %0d code 0x%0h", got.kind, got.char_code);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      chars_out++;
      case (want.kind)
        KIND_DOUBLE: pairs++;
        KIND_ESCAPE: escapes++;
        KIND_END:    ends++;
        default: ;
      endcase
      check_field("kind", want.kind, got.kind);
      check_field("char_code", want.char_code, got.char_code);
      check_field("trailing_punct", want.trailing_punct, got.trailing_punct);
      check_field("counted", want.counted, got.counted);
      check_field("printable_count", want.printable_count, got.printable_count);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_text_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic [15:0] out_char_code;
  logic        out_trailing_punct;
  logic        out_counted;
  logic [15:0] out_printable_count;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_language;

  dbcs_char_scoreboard sb = new();
  bit idle_enable   = 1'b1;
  int hold_requests = 0;

  dbcs_text_char_decoder_top uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_text_byte        (in_text_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_char_code       (out_char_code),
    .out_trailing_punct  (out_trailing_punct),
    .out_counted         (out_counted),
    .out_printable_count (out_printable_count),
    .out_last            (out_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_language        (cfg_language)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin : result_stall
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left   = 0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else
        out_stall = idle_enable && ($urandom_range(99) < 7);
    end
  end

  initial begin : result_monitor
    res_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.kind            = out_kind;
        got.char_code       = out_char_code;
        got.trailing_punct  = out_trailing_punct;
        got.counted         = out_counted;
        got.printable_count = out_printable_count;
        got.last            = out_last;
        sb.check_char(got);
      end
    end
  end

  // all driving tasks start and end on a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (idle_enable && $urandom_range(99) < 7) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_text_byte = b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_language(input logic [3:0] l);
    cfg_valid    = 1'b1;
    cfg_language = l;
    do @(posedge clk); while (!cfg_ready);
    sb.set_language(l);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait out every owed character, then give a held byte time to settle
  task automatic settle();
    while (sb.pending() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic send_token(input logic [3:0] lang);
    int         sel;
    bit         dbl;
    logic [7:0] lead;
    logic [7:0] trail;
    logic [7:0] marks[6] = '{8'h21, 8'h3F, 8'h2C, 8'h2E, 8'h3B, 8'h3A};
    dbl = (lang >= LANG_KOREAN && lang <= LANG_GB);
    sel = dbl ? $urandom_range(99) : $urandom_range(45, 99);
    if (sel < 45) begin
      case (lang)
        LANG_KOREAN: begin
          lead  = 8'($urandom_range(8'hB0, 8'hC8));
          trail = 8'($urandom_range(8'hA1, 8'hFE));
        end
        LANG_BIG5: begin
          lead  = $urandom_range(1) ? 8'($urandom_range(8'hA1, 8'hC6))
                                    : 8'($urandom_range(8'hC9, 8'hF9));
          trail = $urandom_range(1) ? 8'($urandom_range(8'h40, 8'h7E))
                                    : 8'($urandom_range(8'hA1, 8'hFE));
        end
        LANG_SJIS: begin
          lead  = $urandom_range(1) ? 8'($urandom_range(8'h81, 8'h9F))
                                    : 8'($urandom_range(8'hE0, 8'hEF));
          trail = $urandom_range(1) ? 8'($urandom_range(8'h40, 8'h7E))
                                    : 8'($urandom_range(8'h80, 8'hFC));
        end
        default: begin
          lead  = 8'($urandom_range(8'hA1, 8'hF7));
          trail = 8'($urandom_range(8'hA1, 8'hFE));
        end
      endcase
      // around the edges of the punctuation block now and then
      if ($urandom_range(3) == 0) begin
        case (lang)
          LANG_BIG5: begin lead = 8'hA1; trail = 8'($urandom_range(8'h3F, 8'h55)); end
          LANG_SJIS: begin lead = 8'h81; trail = 8'($urandom_range(8'h3F, 8'h53)); end
          LANG_GB:   begin lead = 8'hA1; trail = 8'($urandom_range(8'h9F, 8'hAF)); end
          default: ;
        endcase
      end
      // any trail at all, which may break the pair
      if (sel >= 35)
        trail = 8'($urandom_range(255));
      send_byte(lead);
      send_byte(trail);
    end else if (sel < 53) begin
      send_byte(BYTE_CARET);
      send_byte(8'($urandom_range(8'h30, 8'h39)));
    end else if (sel < 58) begin
      send_byte(BYTE_CARET);
      send_byte(8'($urandom_range(255)));
    end else if (sel < 63)
      send_byte($urandom_range(1) ? BYTE_LF : BYTE_CR);
    else if (sel < 72)
      send_byte(marks[$urandom_range(5)]);
    else if (sel < 98)
      send_byte(8'($urandom_range(1, 255)));
    else
      send_byte(BYTE_NUL);
  endtask

  initial begin : stimulus
    logic [3:0]  phase_lang[12] = '{LANG_KOREAN, LANG_BIG5, LANG_SJIS, LANG_GB,
                                    LANG_SINGLE, LANG_SPARE_13, LANG_SPARE_TOP,
                                    LANG_SPARE_LO, LANG_BIG5, LANG_GB, LANG_SJIS,
                                    LANG_KOREAN};
    int unsigned start;
    int          ntok;

    in_valid     = 1'b0;
    in_text_byte = 8'h00;
    cfg_valid    = 1'b0;
    cfg_language = LANG_SINGLE;
    rst_n        = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single-byte text: extremes, punctuation, line ends, escape and a lone caret
    write_language(LANG_SINGLE);
    send_byte(8'h41);
    send_byte(8'hFF);
    send_byte(8'h21);
    send_byte(BYTE_LF);
    send_byte(BYTE_CR);
    send_byte(BYTE_CARET);
    send_byte(8'h35);
    send_byte(BYTE_CARET);
    send_byte(8'h78);
    send_byte(BYTE_NUL);

    // punctuation pair, then a lead flushed by the end of string
    settle();
    write_language(LANG_BIG5);
    send_byte(8'hA1);
    send_byte(8'h40);
    send_byte(8'hA1);
    send_byte(BYTE_NUL);

    // bad trail, then a caret flushed by the end of string
    settle();
    write_language(LANG_SJIS);
    send_byte(8'h81);
    send_byte(8'h30);
    send_byte(BYTE_CARET);
    send_byte(BYTE_NUL);

    // language switched while a lead is held
    settle();
    write_language(LANG_KOREAN);
    send_byte(8'hB0);
    settle();
    write_language(LANG_GB);
    send_byte(8'hA1);

    settle();
    write_language(LANG_SPARE_TOP);
    send_byte(8'hB0);
    send_byte(8'hA1);
    send_byte(BYTE_NUL);

    for (int p = 0; p < 12; p++) begin
      settle();
      write_language(p < 8 ? phase_lang[p] : ($urandom_range(4) == 0 ?
                     4'($urandom_range(15)) : phase_lang[p]));
      if (p == 2)
        hold_requests++;
      idle_enable = (p != 4);
      start = sb.bytes_in;
      while (sb.bytes_in - start < PHASE_ITEMS) begin
        ntok = $urandom_range(1, 24);
        repeat (ntok) send_token(phase_lang[p] == cfg_language ? phase_lang[p] : cfg_language);
        // some strings run on unterminated into the next phase
        if ($urandom_range(99) < 85)
          send_byte(BYTE_NUL);
      end
    end
    idle_enable = 1'b1;

    settle();
    repeat (20) @(negedge clk);
    $display("run covered %0d text bytes and %0d characters: %0d pairs, %0d colour escapes,",
             sb.bytes_in, sb.chars_out, sb.pairs, sb.escapes);
    $display("and %0d string ends across every language setting", sb.ends);
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
